// File: src/input_current_foldback_probe_assert.svh
// Assertion macros used by the checker of the input current foldback probe.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef INPUT_CURRENT_FOLDBACK_PROBE_ASSERT_SVH
`define INPUT_CURRENT_FOLDBACK_PROBE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/icfb_pkg.sv
package icfb_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  // Reset values of the configuration registers.
  localparam logic [12:0] MAX_DROOP_RESET     = 13'd400;
  localparam logic [10:0] PROBE_START_RESET   = 11'd300;
  localparam logic [7:0]  PROBE_STEP_RESET    = 8'd25;
  localparam logic [10:0] LIMIT_CEILING_RESET = 11'd2000;

  // Legal range of any applied current limit.
  localparam logic [10:0] LIMIT_FLOOR_MA = 11'd90;
  localparam logic [10:0] LIMIT_TOP_MA   = 11'd2000;

  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_NOLOAD   = 3'd2,
    MODE_PROBE    = 3'd3,
    MODE_DEBOUNCE = 3'd4,
    MODE_SETTLE   = 3'd5
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_DROOP     = 2'd0,
    CFG_PROBE_START   = 2'd1,
    CFG_PROBE_STEP    = 2'd2,
    CFG_LIMIT_CEILING = 2'd3
  } cfg_reg_t;

  // Configuration as seen by the datapath; the ceiling is already held in range.
  typedef struct packed {
    logic [12:0] max_droop_mv;
    logic [10:0] probe_start_ma;
    logic [7:0]  probe_step_ma;
    logic [10:0] ceiling_ma;
  } cfg_t;

  typedef struct packed {
    logic       supply_present;
    logic [7:0] supply_volt_code;
    logic [7:0] supply_curr_code;
  } tick_t;

  typedef struct packed {
    mode_t       mode;
    logic        last_present;
    logic [12:0] noload_mv;
    logic [10:0] target_ma;
  } state_t;

  typedef struct packed {
    logic        limit_written;
    logic        charger_enabled;
    logic [7:0]  limit_code;
    logic [10:0] target_ma;
    mode_t       mode;
    logic        fast_poll;
    logic        gauge_route_request;
  } result_t;

endpackage

// File: src/icfb_if.sv
// Poll tick channel: one transfer carries one set of supply readings.
interface icfb_tick_if;
  logic       valid;
  logic       ready;
  logic       supply_present;
  logic [7:0] supply_volt_code;
  logic [7:0] supply_curr_code;

  modport source (output valid, supply_present, supply_volt_code, supply_curr_code,
                  input ready);
  modport sink (input valid, supply_present, supply_volt_code, supply_curr_code,
                output ready);
endinterface

// Result channel: one transfer per poll tick.
interface icfb_result_if;
  logic        valid;
  logic        ready;
  logic        limit_written;
  logic        charger_enabled;
  logic [7:0]  limit_code;
  logic [10:0] target_ma;
  logic [2:0]  mode;
  logic        fast_poll;
  logic        gauge_route_request;

  modport source (output valid, limit_written, charger_enabled, limit_code, target_ma,
                  mode, fast_poll, gauge_route_request,
                  input ready);
  modport sink (input valid, limit_written, charger_enabled, limit_code, target_ma,
                mode, fast_poll, gauge_route_request,
                output ready);
endinterface

// File: src/icfb_cfg.sv
module icfb_cfg import icfb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [12:0] max_droop_mv;
  logic [10:0] probe_start_ma;
  logic [7:0]  probe_step_ma;
  logic [10:0] limit_ceiling_ma;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_droop_mv     <= MAX_DROOP_RESET;
      probe_start_ma   <= PROBE_START_RESET;
      probe_step_ma    <= PROBE_STEP_RESET;
      limit_ceiling_ma <= LIMIT_CEILING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAX_DROOP:     max_droop_mv     <= cfg_data;
        CFG_PROBE_START:   probe_start_ma   <= cfg_data[10:0];
        CFG_PROBE_STEP:    probe_step_ma    <= cfg_data[7:0];
        CFG_LIMIT_CEILING: limit_ceiling_ma <= cfg_data[10:0];
      endcase
    end
  end

  // The ceiling in use never leaves the legal limit range.
  always_comb begin
    cfg.max_droop_mv   = max_droop_mv;
    cfg.probe_start_ma = probe_start_ma;
    cfg.probe_step_ma  = probe_step_ma;
    if (limit_ceiling_ma < LIMIT_FLOOR_MA) begin
      cfg.ceiling_ma = LIMIT_FLOOR_MA;
    end else if (limit_ceiling_ma > LIMIT_TOP_MA) begin
      cfg.ceiling_ma = LIMIT_TOP_MA;
    end else begin
      cfg.ceiling_ma = limit_ceiling_ma;
    end
  end

endmodule

// File: src/icfb_step.sv
module icfb_step import icfb_pkg::*; (
  input  tick_t   tick,
  input  state_t  state,
  input  cfg_t    cfg,
  output state_t  state_next,
  output result_t res
);

  // 6554 / 65536 is within 7e-6 of one tenth, exact for every quotient below 2048 / 10.
  localparam logic [23:0] RECIP_TEN = 24'd6554;

  logic [12:0] volt_mv;
  logic [11:0] curr_ma;
  logic        droop;
  logic [11:0] raised;
  logic [11:0] back;
  mode_t       mode_next;
  logic [12:0] noload_next;
  logic [10:0] target_next;
  logic        written;
  logic        gauge;
  logic [10:0] above_floor;
  logic [23:0] code_prod;

  function automatic logic [10:0] clamp_limit(input logic [11:0] val,
                                              input logic [10:0] ceil);
    logic [11:0] v;
    v = val;
    if (v != '0 && v < 12'(LIMIT_FLOOR_MA)) begin
      v = 12'(LIMIT_FLOOR_MA);
    end
    if (v > 12'(ceil)) begin
      v = 12'(ceil);
    end
    return v[10:0];
  endfunction

  assign volt_mv = 13'(tick.supply_volt_code) * 13'd25;
  assign curr_ma = 12'(tick.supply_curr_code) * 12'd10;
  assign droop   = (state.noload_mv > volt_mv) &&
                   ((state.noload_mv - volt_mv) > cfg.max_droop_mv);

  // Raise by one step only while the drawn current exceeds the target.
  assign raised = (12'(state.target_ma) < curr_ma) ?
                  12'(state.target_ma) + 12'(cfg.probe_step_ma) : 12'(state.target_ma);

  // Stepping back never wraps: a target at or below the step falls to the floor.
  always_comb begin
    if (state.target_ma == '0) begin
      back = '0;
    end else if (12'(state.target_ma) <= 12'(cfg.probe_step_ma)) begin
      back = 12'(LIMIT_FLOOR_MA);
    end else begin
      back = 12'(state.target_ma) - 12'(cfg.probe_step_ma);
    end
  end

  // Next state.
  always_comb begin
    mode_next   = state.mode;
    noload_next = state.noload_mv;
    target_next = state.target_ma;
    written     = 1'b0;
    gauge       = 1'b0;
    if (tick.supply_present != state.last_present || state.mode == MODE_INIT) begin
      mode_next   = tick.supply_present ? MODE_NOLOAD : MODE_IDLE;
      target_next = '0;
      written     = 1'b1;
    end else begin
      unique case (state.mode)
        MODE_NOLOAD: begin
          noload_next = volt_mv;
          target_next = clamp_limit(12'(cfg.probe_start_ma), cfg.ceiling_ma);
          written     = 1'b1;
          gauge       = 1'b1;
          mode_next   = MODE_PROBE;
        end
        MODE_PROBE: begin
          if (droop) begin
            mode_next = MODE_DEBOUNCE;
          end else begin
            target_next = clamp_limit(raised, cfg.ceiling_ma);
            written     = 1'b1;
          end
        end
        MODE_DEBOUNCE: begin
          if (droop) begin
            target_next = clamp_limit(back, cfg.ceiling_ma);
            written     = 1'b1;
            mode_next   = MODE_SETTLE;
          end else begin
            mode_next = MODE_PROBE;
          end
        end
        default: begin
          mode_next = state.mode;
        end
      endcase
    end
  end

  assign state_next.mode         = mode_next;
  assign state_next.last_present = tick.supply_present;
  assign state_next.noload_mv    = noload_next;
  assign state_next.target_ma    = target_next;

  assign above_floor = target_next - LIMIT_FLOOR_MA;
  assign code_prod   = 24'(above_floor) * RECIP_TEN;

  // Outputs.
  always_comb begin
    res.limit_written       = written;
    res.charger_enabled     = (target_next != '0);
    res.limit_code          = (target_next >= LIMIT_FLOOR_MA) ? code_prod[23:16] : 8'd0;
    res.target_ma           = target_next;
    res.mode                = mode_next;
    res.fast_poll           = (mode_next == MODE_NOLOAD) || (mode_next == MODE_PROBE) ||
                              (mode_next == MODE_DEBOUNCE);
    res.gauge_route_request = gauge;
  end

endmodule

// File: src/input_current_foldback_probe.sv
// Input current foldback probe. Every transfer on the tick channel carries one poll of the
// supply: the present bit and the raw voltage (25 mV per code) and current (10 mA per code)
// readings. For each tick exactly one transfer leaves on the result channel, giving the
// current limit in force, its register code, whether the limit was written on that tick,
// the mode after the tick, the fast polling hint and a one-tick request to route the gauge
// link to the host. The block accepts a tick in every clock cycle unless a stalled result
// transfer holds both the input and the result register full. A tick waits in the input
// register, then passes through the mode and limit update into the result register. The
// combinational update of the mode, the no-load voltage and the target sets the rate.
// Configuration registers are written through cfg_write, cfg_index and cfg_data; a write
// takes effect at once and must only be made while no tick is in flight.
module input_current_foldback_probe import icfb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  icfb_tick_if.sink              tick,
  icfb_result_if.source          result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam state_t STATE_RESET = '{
    mode:         MODE_INIT,
    last_present: 1'b0,
    noload_mv:    13'd0,
    target_ma:    11'd0
  };

  cfg_t    cfg;
  logic    tick_valid;
  tick_t   tick_q;
  state_t  state;
  state_t  state_next;
  result_t res;
  logic    result_valid;
  result_t result_q;
  logic    result_free;
  logic    step_fire;

  icfb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  icfb_step u_step (
    .tick       (tick_q),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .res        (res)
  );

  // The result register is free when it is empty or its transfer completes this cycle.
  // The held tick moves on, updating the state, whenever the result register is free, so a
  // new tick is taken while the previous result still waits for its transfer.
  assign result_free = !result_valid || result.ready;
  assign step_fire   = tick_valid && result_free;
  assign tick.ready  = !tick_valid || result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= STATE_RESET;
    end else begin
      if (tick.ready) begin
        tick_valid <= tick.valid;
      end
      if (result_free) begin
        result_valid <= tick_valid;
      end
      if (step_fire) begin
        state <= state_next;
      end
    end
  end

  // Payload registers need no reset; the valid flags above guard them.
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.supply_present   <= tick.supply_present;
      tick_q.supply_volt_code <= tick.supply_volt_code;
      tick_q.supply_curr_code <= tick.supply_curr_code;
    end
    if (step_fire) begin
      result_q <= res;
    end
  end

  assign result.valid               = result_valid;
  assign result.limit_written       = result_q.limit_written;
  assign result.charger_enabled     = result_q.charger_enabled;
  assign result.limit_code          = result_q.limit_code;
  assign result.target_ma           = result_q.target_ma;
  assign result.mode                = result_q.mode;
  assign result.fast_poll           = result_q.fast_poll;
  assign result.gauge_route_request = result_q.gauge_route_request;

endmodule

// File: src/icfb_checker.sv
`include "input_current_foldback_probe_assert.svh"

module icfb_checker import icfb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        limit_written,
  input logic        charger_enabled,
  input logic [7:0]  limit_code,
  input logic [10:0] target_ma,
  input logic [2:0]  mode,
  input logic        fast_poll,
  input logic        gauge_route_request
);

  `ICFB_ASSERT_NEXT(a_result_held, valid && !ready, valid && $stable(target_ma) && $stable(limit_code) && $stable(mode), "result changed while stalled")
  `ICFB_ASSERT_SAME(a_enable_matches, valid, charger_enabled == (target_ma != 11'd0), "charger enable disagrees with target")
  `ICFB_ASSERT_SAME(a_code_range, valid, charger_enabled ? (target_ma >= LIMIT_FLOOR_MA && target_ma <= LIMIT_TOP_MA && limit_code <= 8'd191) : (limit_code == 8'd0), "limit code or target out of range")
  `ICFB_ASSERT_SAME(a_fast_poll, valid, fast_poll == (mode == MODE_NOLOAD || mode == MODE_PROBE || mode == MODE_DEBOUNCE), "fast poll disagrees with mode")
  `ICFB_ASSERT_SAME(a_gauge_pulse, valid && gauge_route_request, limit_written && mode == MODE_PROBE, "gauge request outside the start of probing")

endmodule

bind input_current_foldback_probe icfb_checker u_icfb_checker (
  .clk                 (clk),
  .rst                 (rst),
  .valid               (result.valid),
  .ready               (result.ready),
  .limit_written       (result.limit_written),
  .charger_enabled     (result.charger_enabled),
  .limit_code          (result.limit_code),
  .target_ma           (result.target_ma),
  .mode                (result.mode),
  .fast_poll           (result.fast_poll),
  .gauge_route_request (result.gauge_route_request)
);
